@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define EIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define EIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/eip_pkg.sv @@
package eip_pkg;

  // Packet class codes
  localparam logic [2:0] CLASS_NONE  = 3'd0;
  localparam logic [2:0] CLASS_TCP   = 3'd1;
  localparam logic [2:0] CLASS_UDP   = 3'd2;
  localparam logic [2:0] CLASS_ICMP  = 3'd3;
  localparam logic [2:0] CLASS_OTHER = 3'd4;

  // Header layout and limits
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_HDR_LEN = 16'd14;
  localparam logic [15:0] IP_MIN_LEN  = 16'd20;
  localparam logic [15:0] TCP_MIN_LEN = 16'd20;
  localparam logic [15:0] UDP_MIN_LEN = 16'd8;
  localparam logic [15:0] ICMP_MIN_LEN = 16'd4;
  localparam logic [15:0] OFF_MAX     = 16'hffff;

  // Protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Byte offsets within the frame; REL_FLAGS is relative to the payload start
  localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFF_IHL      = 16'd14;
  localparam logic [15:0] OFF_LEN_HI   = 16'd16;
  localparam logic [15:0] OFF_LEN_LO   = 16'd17;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_SRC_LO   = 16'd26;
  localparam logic [15:0] OFF_SRC_HI   = 16'd29;
  localparam logic [15:0] OFF_DST_LO   = 16'd30;
  localparam logic [15:0] OFF_DST_HI   = 16'd33;
  localparam logic [16:0] REL_FLAGS    = 17'd13;

  // One parsed frame summary
  typedef struct packed {
    logic [2:0]  packet_class;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] total_length;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [4:0]  tcp_flags;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
  } res_t;

endpackage

@@ hw/rtl/eip_parse.sv @@
module eip_parse
  import eip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output res_t       res
);

  logic [15:0] off_r, off_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [5:0]  hl_r, hl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;
  logic [7:0]  flag_r, flag_nxt;

  logic [16:0] pay_base;
  logic [16:0] rel;
  logic        in_pay;
  logic [15:0] rem;
  logic [15:0] prem;
  logic        ip_ok;

  // Header field capture for the byte at the current offset
  always_comb begin
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    flag_nxt   = flag_r;

    if (off_r == OFF_ETYPE_HI) kind_nxt[15:8] = data_byte;
    if (off_r == OFF_ETYPE_LO) kind_nxt[7:0] = data_byte;
    hl_nxt = (off_r == OFF_IHL) ? {data_byte[3:0], 2'b00} : hl_r;
    if (off_r == OFF_LEN_HI) len_nxt[15:8] = data_byte;
    if (off_r == OFF_LEN_LO) len_nxt[7:0] = data_byte;
    if (off_r == OFF_PROTO) proto_nxt = data_byte;
    if (off_r >= OFF_SRC_LO && off_r <= OFF_SRC_HI) src_nxt = {src_r[23:0], data_byte};
    if (off_r >= OFF_DST_LO && off_r <= OFF_DST_HI) dst_nxt = {dst_r[23:0], data_byte};

    // Payload capture; a fresh IHL at offset 14 already moves the payload start
    pay_base = {1'b0, ETH_HDR_LEN} + {11'd0, hl_nxt};
    in_pay   = {1'b0, off_r} >= pay_base;
    rel      = {1'b0, off_r} - pay_base;
    if (in_pay) begin
      if (rel == 17'd0) first_nxt[15:8] = data_byte;
      if (rel == 17'd1) first_nxt[7:0] = data_byte;
      if (rel == 17'd2) second_nxt[15:8] = data_byte;
      if (rel == 17'd3) second_nxt[7:0] = data_byte;
      if (rel == REL_FLAGS) flag_nxt = data_byte;
    end

    // Byte count saturates
    off_nxt = (off_r != OFF_MAX) ? off_r + 16'd1 : off_r;
  end

  // Classification of the frame ending with this byte
  always_comb begin
    rem   = off_nxt - ETH_HDR_LEN;
    prem  = rem - {10'd0, hl_nxt};
    ip_ok = (off_nxt >= ETH_HDR_LEN) && (kind_nxt == ETYPE_IPV4) &&
            (rem >= IP_MIN_LEN) && (rem >= {10'd0, hl_nxt});
    res = '0;
    if (ip_ok) begin
      res.ip_protocol         = proto_nxt;
      res.source_address      = src_nxt;
      res.destination_address = dst_nxt;
      res.total_length        = len_nxt;
      if (proto_nxt == PROTO_TCP && prem >= TCP_MIN_LEN) begin
        res.packet_class     = CLASS_TCP;
        res.source_port      = first_nxt;
        res.destination_port = second_nxt;
        res.tcp_flags        = flag_nxt[4:0];
      end else if (proto_nxt == PROTO_UDP && prem >= UDP_MIN_LEN) begin
        res.packet_class     = CLASS_UDP;
        res.source_port      = first_nxt;
        res.destination_port = second_nxt;
      end else if (proto_nxt == PROTO_ICMP && prem >= ICMP_MIN_LEN) begin
        res.packet_class = CLASS_ICMP;
        res.icmp_type    = first_nxt[15:8];
        res.icmp_code    = first_nxt[7:0];
      end else begin
        res.packet_class = CLASS_OTHER;
      end
    end
  end

  // Frame state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      kind_r   <= '0;
      hl_r     <= '0;
      proto_r  <= '0;
      len_r    <= '0;
      src_r    <= '0;
      dst_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
      flag_r   <= '0;
    end else if (take) begin
      if (last_byte) begin
        off_r    <= '0;
        kind_r   <= '0;
        hl_r     <= '0;
        proto_r  <= '0;
        len_r    <= '0;
        src_r    <= '0;
        dst_r    <= '0;
        first_r  <= '0;
        second_r <= '0;
        flag_r   <= '0;
      end else begin
        off_r    <= off_nxt;
        kind_r   <= kind_nxt;
        hl_r     <= hl_nxt;
        proto_r  <= proto_nxt;
        len_r    <= len_nxt;
        src_r    <= src_nxt;
        dst_r    <= dst_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        flag_r   <= flag_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/ethernet_ipv4_header_parser.sv @@
// Ethernet / IPv4 header parser.
// Input channel: one frame byte per transfer (in_data_byte, in_last_byte),
// in wire order, in_last_byte set on the final byte of the frame.
// Result channel: one summary per frame (class, protocol, addresses, total
// length, ports, TCP flags, ICMP type/code), sent after the final byte.
// Throughput: one byte per cycle while the input channel is not stalled.
// Each byte passes an input register and then the field capture and
// classification logic; the summary of the final byte goes to the result
// register. The receiver may stall the result register; bytes that are not
// final keep flowing, and a final byte waits in the input register, which
// stalls the input channel, until the pending result is taken.
// Reset clears the byte counter, all captured fields and both valid flags;
// the first byte after reset is offset zero of a new frame.
`include "assert_macros.svh"

module ethernet_ipv4_header_parser
  import eip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_packet_class,
  output logic [7:0]  out_ip_protocol,
  output logic [31:0] out_source_address,
  output logic [31:0] out_destination_address,
  output logic [15:0] out_total_length,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [4:0]  out_tcp_flags,
  output logic [7:0]  out_icmp_type,
  output logic [7:0]  out_icmp_code
);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       take;
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;

  // A final byte may only move on when the result slot can take it
  assign s1_go    = !(out_valid_r && out_stall && s1_last_r);
  assign in_stall = s1_valid_r && !s1_go;
  assign take     = s1_valid_r && s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  eip_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_packet_class        = res_r.packet_class;
  assign out_ip_protocol         = res_r.ip_protocol;
  assign out_source_address      = res_r.source_address;
  assign out_destination_address = res_r.destination_address;
  assign out_total_length        = res_r.total_length;
  assign out_source_port         = res_r.source_port;
  assign out_destination_port    = res_r.destination_port;
  assign out_tcp_flags           = res_r.tcp_flags;
  assign out_icmp_type           = res_r.icmp_type;
  assign out_icmp_code           = res_r.icmp_code;

  // Checks
  `EIP_ASSERT_ALWAYS(a_reset_clears_out, $past(!rst_n) |-> !out_valid_r, "result valid after reset")
  `EIP_ASSERT(a_stall_only_on_last, in_stall |-> (s1_last_r && out_valid_r && out_stall), "input stalled without a pending final byte")
  `EIP_ASSERT(a_none_is_zero, (out_valid_r && res_r.packet_class == CLASS_NONE) |-> (res_r.ip_protocol == 8'd0 && res_r.source_address == 32'd0 && res_r.total_length == 16'd0), "unrecorded frame carries fields")
  `EIP_ASSERT(a_ports_only_l4, (out_valid_r && res_r.packet_class != CLASS_TCP && res_r.packet_class != CLASS_UDP) |-> (res_r.source_port == 16'd0 && res_r.destination_port == 16'd0), "ports set for a non TCP/UDP frame")
  `EIP_ASSERT(a_class_range, out_valid_r |-> (res_r.packet_class <= CLASS_OTHER), "bad packet class")

endmodule
